// ===== rtl/core/vfb_pkg.sv =====
// Shared types and codes for the voxel frame buffer.
`timescale 1ns / 1ps
`default_nettype none

package vfb_pkg;

   localparam logic [2:0] OP_BLEND      = 3'd0;
   localparam logic [2:0] OP_CLEAR_CELL = 3'd1;
   localparam logic [2:0] OP_READ       = 3'd2;
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
   localparam logic [2:0] OP_SHIFT      = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int COLOR_W = 24;

   typedef struct packed {
      logic [2:0] opcode;
      logic [2:0] coord_x;
      logic [2:0] coord_y;
      logic [2:0] coord_z;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [1:0] shift_axis;
      logic       shift_toward_low;
   } vfb_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       read_valid;
   } vfb_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/vfb_ram.sv =====
// Simple dual-port color memory with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vfb_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 24
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [DW-1:0]      rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/voxel_frame_buffer.sv =====
// Top level of the voxel frame buffer: command decode, sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block stores a cube of SIDE x SIDE x SIDE voxels of 24-bit RGB color in one
// synchronous memory and executes one command transaction at a time. For blend,
// clear cell and read, the cell is read from memory at the accepting edge and the
// modified word is written back in the following cycle. Clear all walks the memory
// one word per cycle. A shift copies each cell with a read followed by a write over
// the single memory, then blackens the vacated plane one word per cycle; a shift on
// axis 3 is a no-op. After reset the block clears the memory to black and holds
// req_ready low during that pass. A result waits in an output register, so the next
// command is taken while an earlier result is still pending; only a second result
// that finds the register full waits in res_ff until rsp_ready frees it.
// Every command returns exactly one result transaction; only a read inside the cube
// returns a color and read_valid set.
module voxel_frame_buffer
   import vfb_pkg::*;
#(
   parameter int SIDE = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire vfb_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output vfb_rsp_type      rsp_data
);

   localparam int CELLS = SIDE * SIDE * SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(SIDE);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [CW-1:0] LAST_COORD = CW'(SIDE - 1);
   localparam logic [3:0]    SIDE_W     = 4'(SIDE);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CELL,
      S_CLR,
      S_SHRD,
      S_SHWR,
      S_DONE
   } state_type;

   // Linear word address of cell (x,y,z).
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
      logic [AW-1:0] side_a;
      side_a = AW'(SIDE);
      return AW'((AW'(x) * side_a + AW'(y)) * side_a + AW'(z));
   endfunction

   // Address of the cell at plane p along the axis, other coordinates u and v.
   function automatic logic [AW-1:0] plane_addr(input logic [1:0]    axis,
                                                input logic [CW-1:0] p,
                                                input logic [CW-1:0] u,
                                                input logic [CW-1:0] v);
      logic [AW-1:0] a;
      case (axis)
         AXIS_X:  a = cell_addr(p, u, v);
         AXIS_Y:  a = cell_addr(u, p, v);
         default: a = cell_addr(u, v, p);
      endcase
      return a;
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   state_type     state_ff;
   vfb_req_type   req_ff;
   logic [AW-1:0] addr_ff;
   logic          inside_ff;
   logic [AW-1:0] clr_ff;
   logic [CW-1:0] dst_ff;
   logic [CW-1:0] u_ff;
   logic [CW-1:0] v_ff;
   vfb_rsp_type   res_ff;
   logic          rsp_valid_ff;
   vfb_rsp_type   rsp_data_ff;

   logic          accept;
   logic          slot_free;
   logic          req_inside;
   logic [AW-1:0] req_addr;
   logic [CW-1:0] src_plane;
   logic [CW-1:0] end_plane;
   logic          uv_last;
   logic          on_end_plane;
   logic [AW-1:0] dst_addr;
   logic [AW-1:0] src_addr;
   vfb_rsp_type   cell_rsp;
   logic [COLOR_W-1:0] blend_word;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [COLOR_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [COLOR_W-1:0] ram_rdata;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_inside = ({1'b0, req_data.coord_x} < SIDE_W) &&
                       ({1'b0, req_data.coord_y} < SIDE_W) &&
                       ({1'b0, req_data.coord_z} < SIDE_W);
   assign req_addr = req_inside ? cell_addr(req_data.coord_x[CW-1:0],
                                            req_data.coord_y[CW-1:0],
                                            req_data.coord_z[CW-1:0]) : '0;

   // Shift walk: dst_ff steps plane by plane toward the side that is vacated.
   assign src_plane    = req_ff.shift_toward_low ? dst_ff + 1'b1 : dst_ff - 1'b1;
   assign end_plane    = req_ff.shift_toward_low ? LAST_COORD : '0;
   assign uv_last      = (u_ff == LAST_COORD) && (v_ff == LAST_COORD);
   assign on_end_plane = (dst_ff == end_plane);
   assign dst_addr     = plane_addr(req_ff.shift_axis, dst_ff, u_ff, v_ff);
   assign src_addr     = plane_addr(req_ff.shift_axis, src_plane, u_ff, v_ff);

   assign blend_word = {sat_add(ram_rdata[23:16], req_ff.red_in),
                        sat_add(ram_rdata[15:8], req_ff.green_in),
                        sat_add(ram_rdata[7:0], req_ff.blue_in)};

   always_comb begin
      cell_rsp = '0;
      if ((req_ff.opcode == OP_READ) && inside_ff) begin
         cell_rsp.red_out    = ram_rdata[23:16];
         cell_rsp.green_out  = ram_rdata[15:8];
         cell_rsp.blue_out   = ram_rdata[7:0];
         cell_rsp.read_valid = 1'b1;
      end
   end

   // Memory port control. Reads and writes never fall in the same cycle.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;
      unique case (state_ff)
         S_IDLE: begin
            ram_re    = accept;
            ram_raddr = req_addr;
         end
         S_CELL: begin
            ram_waddr = addr_ff;
            if (inside_ff && (req_ff.opcode == OP_BLEND)) begin
               ram_we    = 1'b1;
               ram_wdata = blend_word;
            end else if (inside_ff && (req_ff.opcode == OP_CLEAR_CELL)) begin
               ram_we = 1'b1;
            end
         end
         S_INIT, S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         S_SHRD: begin
            if (on_end_plane) begin
               ram_we    = 1'b1;
               ram_waddr = dst_addr;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = src_addr;
            end
         end
         S_SHWR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_addr;
            ram_wdata = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   vfb_ram #(
      .DEPTH (CELLS),
      .AW    (AW),
      .DW    (COLOR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_CELL) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  req_ff    <= req_data;
                  addr_ff   <= req_addr;
                  inside_ff <= req_inside;
                  clr_ff    <= '0;
                  u_ff      <= '0;
                  v_ff      <= '0;
                  dst_ff    <= req_data.shift_toward_low ? '0 : LAST_COORD;
                  unique case (req_data.opcode)
                     OP_CLEAR_ALL: state_ff <= S_CLR;
                     OP_SHIFT: begin
                        if (req_data.shift_axis == AXIS_X ||
                            req_data.shift_axis == AXIS_Y ||
                            req_data.shift_axis == AXIS_Z) begin
                           state_ff <= S_SHRD;
                        end else begin
                           state_ff <= S_CELL;
                        end
                     end
                     default: state_ff <= S_CELL;
                  endcase
               end
            end
            S_CELL: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= cell_rsp;
                  state_ff     <= S_IDLE;
               end else begin
                  res_ff   <= cell_rsp;
                  state_ff <= S_DONE;
               end
            end
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_CELL) begin
                  res_ff   <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_SHRD: begin
               if (on_end_plane) begin
                  if (uv_last) begin
                     res_ff   <= '0;
                     state_ff <= S_DONE;
                  end else if (v_ff == LAST_COORD) begin
                     v_ff <= '0;
                     u_ff <= u_ff + 1'b1;
                  end else begin
                     v_ff <= v_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_SHWR;
               end
            end
            S_SHWR: begin
               state_ff <= S_SHRD;
               if (v_ff == LAST_COORD) begin
                  v_ff <= '0;
                  if (u_ff == LAST_COORD) begin
                     u_ff   <= '0;
                     dst_ff <= req_ff.shift_toward_low ? dst_ff + 1'b1 : dst_ff - 1'b1;
                  end else begin
                     u_ff <= u_ff + 1'b1;
                  end
               end else begin
                  v_ff <= v_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The single memory is never read and written in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("memory read and write issued together");

   // A result on the output holds, unchanged, until it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result dropped or changed before it was taken");

   // One transaction at a time: no new command right after one is accepted.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("command accepted while another is in progress");

   // The clearing pass after reset never produces a result.
   a_init_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |=> !$rose(rsp_valid_ff))
      else $error("result produced during the clearing pass");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the voxel frame buffer, with directed and random command streams.
`timescale 1ns / 1ps

// The bench keeps its own copy of the color cube and updates it for each command
// transaction that the block accepts. Every command returns exactly one result,
// so the prediction for each accepted command goes onto a queue. The monitor
// compares each result transaction, field by field, with the oldest prediction.
//
// Stimulus comes in two parts. A short directed list covers saturating blends,
// coordinates outside the cube, shifts along every axis in both directions, the
// unused axis code, two unused opcodes, single clears and the full clear. A long
// random stream follows. Most of its coordinates land inside the cube so that
// blends pile up and later reads and shifts see real content. The sender and the
// receiver both pause in random bursts, and the pause rate changes as the run
// goes on. In the last stretch neither side pauses.
module testbench;
   import vfb_pkg::*;

   localparam int SIDE         = 4;
   localparam int CELLS        = SIDE * SIDE * SIDE;
   localparam int RANDOM_CMDS  = 1180;
   // No pauses on either side once this few commands are left to send.
   localparam int CALM_TAIL    = 150;
   // The slowest command is a shift; the post-reset clearing pass also holds req_ready low.
   // The limit allows many times the length of either.
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * (SIDE - 1) * SIDE * SIDE + SIDE * SIDE + 16;
   localparam int MAX_REPORTS  = 10;

   localparam logic [7:0] CHAN_FULL    = 8'd255;
   localparam logic [2:0] OP_NOP_FIRST = 3'd5;
   localparam logic [2:0] OP_NOP_LAST  = 3'd7;
   localparam logic [1:0] AXIS_NONE    = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   vfb_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   vfb_rsp_type rsp_data;

   // These are the commands still to be sent and the results still owed by the block.
   vfb_req_type cmd_queue[$];
   vfb_rsp_type rsp_wanted_q[$];

   // This is the predicted cube. Cell (x,y,z) is word (x*SIDE + y)*SIDE + z.
   logic [23:0] cube_colors [CELLS];

   logic        req_taken = 1'b0;
   vfb_rsp_type wanted;
   int          gap_left = 0;
   int          gap_pct = 0;
   int          stall_left = 0;
   int          stall_pct = 0;
   int          rx_cycles = 0;
   int          quiet_cycles = 0;
   int          cmds_sent = 0;
   int          cmds_taken = 0;
   int          rsps_checked = 0;
   int          reads_hit = 0;
   int          mismatches = 0;
   int          op_count [8];

   voxel_frame_buffer #(
      .SIDE(SIDE)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] chan_sum_sat(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[8] ? CHAN_FULL : total[7:0];
   endfunction

   function automatic int cell_index(input int x, input int y, input int z);
      return (x * SIDE + y) * SIDE + z;
   endfunction

   // This applies one command to the predicted cube and returns the result that it owes.
   function automatic vfb_rsp_type apply_voxel_command(input vfb_req_type cmd);
      vfb_rsp_type result;
      logic [23:0] prior_colors [CELLS];
      logic [23:0] cell_word;
      bit          in_cube;
      int          idx, pos, src_pos, sx, sy, sz;
      result  = '0;
      in_cube = (cmd.coord_x < SIDE) && (cmd.coord_y < SIDE) && (cmd.coord_z < SIDE);
      idx     = in_cube ? cell_index(cmd.coord_x, cmd.coord_y, cmd.coord_z) : 0;
      case (cmd.opcode)
         OP_BLEND: begin
            if (in_cube) begin
               cell_word = cube_colors[idx];
               cube_colors[idx] = {chan_sum_sat(cell_word[23:16], cmd.red_in),
                                   chan_sum_sat(cell_word[15:8], cmd.green_in),
                                   chan_sum_sat(cell_word[7:0], cmd.blue_in)};
            end
         end
         OP_CLEAR_CELL: begin
            if (in_cube) cube_colors[idx] = '0;
         end
         OP_READ: begin
            if (in_cube) begin
               cell_word         = cube_colors[idx];
               result.red_out    = cell_word[23:16];
               result.green_out  = cell_word[15:8];
               result.blue_out   = cell_word[7:0];
               result.read_valid = 1'b1;
            end
         end
         OP_CLEAR_ALL: begin
            foreach (cube_colors[i]) cube_colors[i] = '0;
         end
         OP_SHIFT: begin
            // Each cell takes its neighbor on the upstream side along the axis.
            // The plane that has no upstream neighbor goes black.
            if (cmd.shift_axis != AXIS_NONE) begin
               prior_colors = cube_colors;
               for (int x = 0; x < SIDE; x++) begin
                  for (int y = 0; y < SIDE; y++) begin
                     for (int z = 0; z < SIDE; z++) begin
                        case (cmd.shift_axis)
                           AXIS_X:  pos = x;
                           AXIS_Y:  pos = y;
                           default: pos = z;
                        endcase
                        src_pos = cmd.shift_toward_low ? pos + 1 : pos - 1;
                        sx = x;
                        sy = y;
                        sz = z;
                        case (cmd.shift_axis)
                           AXIS_X:  sx = src_pos;
                           AXIS_Y:  sy = src_pos;
                           default: sz = src_pos;
                        endcase
                        if (src_pos < 0 || src_pos >= SIDE) begin
                           cube_colors[cell_index(x, y, z)] = '0;
                        end else begin
                           cube_colors[cell_index(x, y, z)] =
                              prior_colors[cell_index(sx, sy, sz)];
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   function automatic vfb_req_type make_cmd(input logic [2:0] op, input int x, input int y,
                                            input int z, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [1:0] axis, input bit low);
      vfb_req_type cmd;
      cmd.opcode           = op;
      cmd.coord_x          = 3'(x);
      cmd.coord_y          = 3'(y);
      cmd.coord_z          = 3'(z);
      cmd.red_in           = r;
      cmd.green_in         = g;
      cmd.blue_in          = b;
      cmd.shift_axis       = axis;
      cmd.shift_toward_low = low;
      return cmd;
   endfunction

   // Blends and reads dominate so that content builds up for later shifts to move.
   // Full clears are rare because each one wipes what has built up.
   function automatic vfb_req_type random_cmd();
      vfb_req_type cmd;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
         cmd.opcode = OP_BLEND;
      end else if (pick < 66) begin
         cmd.opcode = OP_READ;
      end else if (pick < 76) begin
         cmd.opcode = OP_CLEAR_CELL;
      end else if (pick < 90) begin
         cmd.opcode = OP_SHIFT;
      end else if (pick < 92) begin
         cmd.opcode = OP_CLEAR_ALL;
      end else begin
         // This may be any code, the unused ones among them.
         cmd.opcode = 3'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < 85) begin
         cmd.coord_x = 3'($urandom_range(0, SIDE - 1));
         cmd.coord_y = 3'($urandom_range(0, SIDE - 1));
         cmd.coord_z = 3'($urandom_range(0, SIDE - 1));
      end else begin
         cmd.coord_x = 3'($urandom_range(0, 7));
         cmd.coord_y = 3'($urandom_range(0, 7));
         cmd.coord_z = 3'($urandom_range(0, 7));
      end
      // Small blend values let a cell climb over several blends before it saturates.
      if (cmd.opcode == OP_BLEND && $urandom_range(0, 1) == 1) begin
         cmd.red_in   = 8'($urandom_range(0, 63));
         cmd.green_in = 8'($urandom_range(0, 63));
         cmd.blue_in  = 8'($urandom_range(0, 63));
      end else begin
         cmd.red_in   = 8'($urandom_range(0, 255));
         cmd.green_in = 8'($urandom_range(0, 255));
         cmd.blue_in  = 8'($urandom_range(0, 255));
      end
      cmd.shift_axis       = 2'($urandom_range(0, 3));
      cmd.shift_toward_low = 1'($urandom_range(0, 1));
      return cmd;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: the command channel changes on the falling edge.
   // ---------------------------------------------------------------------------

   // req_taken tells the driver whether the rising edge just past accepted the
   // transaction that is on the bus. Until it does, valid and payload hold.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // The transaction is still waiting for req_ready.
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
         if (cmds_sent % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 20;
               default: gap_pct = 50;
            endcase
         end
         if (cmd_queue.size() >= CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
            // This starts a pause burst; gap_left counts what remains of it.
            req_valid <= 1'b0;
            gap_left = $urandom_range(0, 7);
         end else begin
            req_data  <= cmd_queue.pop_front();
            req_valid <= 1'b1;
            cmds_sent = cmds_sent + 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // The receiver stalls in bursts of its own, with a rate that changes as the run goes on.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_cycles % 200 == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         rx_cycles = rx_cycles + 1;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (cmd_queue.size() >= CALM_TAIL && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: both channels are sampled on the rising edge.
   // ---------------------------------------------------------------------------

   // The result check comes before the prediction. A result leaving at this edge
   // always belongs to a command accepted at an earlier edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (rsp_wanted_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= MAX_REPORTS) begin
                  $display("[%0t] unexpected result transaction: rgb %02h %02h %02h valid %0b",
                           $realtime, rsp_data.red_out, rsp_data.green_out,
                           rsp_data.blue_out, rsp_data.read_valid);
               end
            end else begin
               wanted = rsp_wanted_q.pop_front();
               rsps_checked = rsps_checked + 1;
               if (rsp_data.red_out !== wanted.red_out ||
                   rsp_data.green_out !== wanted.green_out ||
                   rsp_data.blue_out !== wanted.blue_out ||
                   rsp_data.read_valid !== wanted.read_valid) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= MAX_REPORTS) begin
                     $display({"[%0t] result %0d: expected rgb %02h %02h %02h valid %0b,",
                               " got rgb %02h %02h %02h valid %0b"},
                              $realtime, rsps_checked, wanted.red_out, wanted.green_out,
                              wanted.blue_out, wanted.read_valid, rsp_data.red_out,
                              rsp_data.green_out, rsp_data.blue_out, rsp_data.read_valid);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            wanted = apply_voxel_command(req_data);
            rsp_wanted_q.push_back(wanted);
            op_count[req_data.opcode] = op_count[req_data.opcode] + 1;
            cmds_taken = cmds_taken + 1;
            if (wanted.read_valid) reads_hit = reads_hit + 1;
         end
      end
   end

   // The watchdog counts cycles with work outstanding in which neither channel
   // moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (cmd_queue.size() != 0 || rsp_wanted_q.size() != 0 || req_valid) begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                  $realtime, quiet_cycles, rsp_wanted_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------

   initial begin
      foreach (cube_colors[i]) cube_colors[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;

      // A fresh store must read back black.
      cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      // These blends test saturation. Red overflows, green lands exactly on full scale,
      // and a blend into an already full cell stays full.
      cmd_queue.push_back(make_cmd(OP_BLEND, 0, 0, 0, 8'hF0, 8'h00, 8'h80, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_BLEND, 0, 0, 0, 8'h20, 8'hFF, 8'h7F, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_BLEND, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, AXIS_Z, 1'b1));
      cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, AXIS_NONE, 1'b1));
      cmd_queue.push_back(make_cmd(OP_BLEND, 3, 3, 3, 8'h12, 8'h34, 8'h56, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_BLEND, 1, 2, 3, 8'hAA, 8'h55, 8'h01, AXIS_X, 1'b0));
      // These commands use coordinates outside the cube. Blend and clear change nothing,
      // and the read returns an invalid, black result.
      cmd_queue.push_back(make_cmd(OP_BLEND, 4, 0, 0, 8'hFF, 8'hFF, 8'hFF, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_BLEND, 7, 7, 7, 8'hFF, 8'hFF, 8'hFF, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_READ, 0, 7, 0, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_CLEAR_CELL, 0, 0, 7, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      // The next six shifts walk the cell at (1,2,3) around the cube and back to its start.
      // Cells pushed off an edge are lost.
      cmd_queue.push_back(make_cmd(OP_SHIFT, 7, 7, 7, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_READ, 2, 2, 3, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_Y, 1'b1));
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_Z, 1'b1));
      cmd_queue.push_back(make_cmd(OP_READ, 2, 1, 2, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_Z, 1'b0));
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_Y, 1'b0));
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b1));
      cmd_queue.push_back(make_cmd(OP_READ, 1, 2, 3, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      // A shift with the unused axis code and the unused opcodes must leave the store alone.
      cmd_queue.push_back(make_cmd(OP_SHIFT, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_NONE, 1'b1));
      cmd_queue.push_back(make_cmd(OP_NOP_FIRST, 1, 2, 3, 8'hFF, 8'hFF, 8'hFF, AXIS_Z, 1'b1));
      cmd_queue.push_back(make_cmd(OP_NOP_LAST, 1, 2, 3, 8'hFF, 8'hFF, 8'hFF, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_CLEAR_CELL, 1, 2, 3, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_READ, 1, 2, 3, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));
      cmd_queue.push_back(make_cmd(OP_CLEAR_ALL, 5, 6, 7, 8'hFF, 8'hFF, 8'hFF, AXIS_Y, 1'b1));
      cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00, AXIS_X, 1'b0));

      for (int n = 0; n < RANDOM_CMDS; n++) cmd_queue.push_back(random_cmd());

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The bench sends everything, collects every owed result, and then watches for strays.
      while (cmd_queue.size() != 0 || req_valid) @(posedge clock);
      while (rsp_wanted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"Checked %0d results from %0d commands: %0d blends, %0d reads",
                " (%0d inside the cube), %0d shifts,"},
               rsps_checked, cmds_taken, op_count[OP_BLEND], op_count[OP_READ], reads_hit,
               op_count[OP_SHIFT]);
      $display("  %0d cell clears, %0d full clears, %0d unused opcodes; %0d mismatches.",
               op_count[OP_CLEAR_CELL], op_count[OP_CLEAR_ALL],
               op_count[OP_NOP_FIRST] + op_count[OP_NOP_FIRST + 3'd1] +
               op_count[OP_NOP_LAST], mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
